/* rtl/websocket_frame_deframer_assert.svh */
// Assertion macros for the deframer RTL
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

/* rtl/wsd_pkg.sv */
// Types and constants of the WebSocket frame deframer
package wsd_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_CONTROL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLOSE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK_REQ    = 2'd2;

	localparam logic [6:0] MAX_CONTROL_RST = 7'd125;
	localparam logic [7:0] MAX_CLOSE_RST   = 8'd125;

	localparam logic [3:0] OP_CONT     = 4'h0;
	localparam logic [3:0] OP_TEXT     = 4'h1;
	localparam logic [3:0] OP_BINARY   = 4'h2;
	localparam logic [3:0] OP_CONN_END = 4'h8;
	localparam logic [3:0] OP_PING     = 4'h9;
	localparam logic [3:0] OP_PONG     = 4'hA;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_FRAGMENTED = 3'd1,
		ERR_UNMASKED   = 3'd2,
		ERR_CTRL_LONG  = 3'd3,
		ERR_CONT       = 3'd4,
		ERR_CLOSE_LONG = 3'd5,
		ERR_BAD_OPCODE = 3'd6
	} err_t;

	typedef enum logic [4:0] {
		PH_FIRST   = 5'b00001,
		PH_SECOND  = 5'b00010,
		PH_EXT     = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [6:0] max_control_payload;
		logic [7:0] max_close_frame;
		logic       mask_required;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  opcode;
		logic [62:0] payload_len;
		logic [7:0]  data_byte;
		logic        last;
		err_t        error_code;
	} result_t;

endpackage

/* rtl/wsd_in_if.sv */
// Byte stream channel into the deframer
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       new_stream;

	modport source(output valid, output in_byte, output new_stream, input ready);
	modport sink(input valid, input in_byte, input new_stream, output ready);
endinterface

/* rtl/wsd_out_if.sv */
// Record channel out of the deframer
interface wsd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  opcode;
	logic [62:0] payload_len;
	logic [7:0]  data_byte;
	logic        last;
	logic [2:0]  error_code;

	modport source(output valid, output kind, output opcode, output payload_len,
		output data_byte, output last, output error_code, input ready);
	modport sink(input valid, input kind, input opcode, input payload_len,
		input data_byte, input last, input error_code, output ready);
endinterface

/* rtl/websocket_frame_deframer.sv */
// WebSocket client-to-server deframer: one stream byte in, at most one record out
//
// stream:  one byte per beat (in_byte) plus new_stream, which restarts the
//          parser before that byte is taken.
// records: header record when a header completes, one record per unmasked
//          payload byte (last on the final one), or an error record, after
//          which bytes are dropped until new_stream is raised.
// cfg:     write-only port; cfg_index 0 max_control_payload, 1 max_close_frame,
//          2 mask_required. The user must write it only while the block is idle;
//          the block itself does not enforce this.
// Throughput: one byte per cycle while records.ready is high. The accepted
//          byte sits in an input register; when the output register is free or
//          emptying, the parser state is updated and the record formed into it.
// Stall:   while records.ready is low the output register holds its record;
//          one more byte can wait in the input register, then stream.ready falls.
// Reset:   arst_n clears both registers' valid bits, the parser waits for the
//          first header byte, and the config registers return to 125/125/1.
`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer #(
	parameter int LENGTH_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wsd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	wsd_in_if.sink                          stream,
	wsd_out_if.source                       records
);

	wsd_pkg::cfg_t    cfg;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             new_stream_s1;
	logic             advance;
	logic             produce;
	logic             halted;
	wsd_pkg::result_t res;
	logic             valid_s2;
	wsd_pkg::result_t res_s2;

	wsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input stage moves on whenever the output register is free or emptying
	assign advance      = valid_s1 && (!valid_s2 || records.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1       <= stream.in_byte;
			new_stream_s1 <= stream.new_stream;
		end
	end

	wsd_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.in_byte    (byte_s1),
		.new_stream (new_stream_s1),
		.cfg        (cfg),
		.produce    (produce),
		.res        (res),
		.halted     (halted)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && produce) begin
			valid_s2 <= 1'b1;
		end else if (records.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res_s2 <= res;
		end
	end

	assign records.valid       = valid_s2;
	assign records.kind        = res_s2.kind;
	assign records.opcode      = res_s2.opcode;
	assign records.payload_len = res_s2.payload_len;
	assign records.data_byte   = res_s2.data_byte;
	assign records.last        = res_s2.last;
	assign records.error_code  = res_s2.error_code;

	`WSD_ASSERT_NEXT(a_error_halts, clk, arst_n,
		advance && produce && res.kind == wsd_pkg::KIND_ERROR, halted)
	`WSD_ASSERT_NOW(a_error_record_clean, clk, arst_n,
		valid_s2 && res_s2.kind == wsd_pkg::KIND_ERROR,
		!res_s2.last && res_s2.data_byte == 8'd0 && res_s2.error_code != wsd_pkg::ERR_NONE)
	`WSD_ASSERT_NOW(a_empty_header_last, clk, arst_n,
		valid_s2 && res_s2.kind == wsd_pkg::KIND_HEADER,
		res_s2.last == (res_s2.payload_len == 63'd0))
	`WSD_ASSERT_NOW(a_halted_silent, clk, arst_n,
		advance && halted && !new_stream_s1, !produce)

endmodule

/* rtl/wsd_cfg_regs.sv */
// Configuration registers of the deframer
module wsd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wsd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output wsd_pkg::cfg_t                  cfg
);

	wsd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_control_payload <= wsd_pkg::MAX_CONTROL_RST;
			cfg_q.max_close_frame     <= wsd_pkg::MAX_CLOSE_RST;
			cfg_q.mask_required       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				wsd_pkg::REG_MAX_CONTROL: cfg_q.max_control_payload <= cfg_data[6:0];
				wsd_pkg::REG_MAX_CLOSE:   cfg_q.max_close_frame     <= cfg_data;
				wsd_pkg::REG_MASK_REQ:    cfg_q.mask_required       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/wsd_parser.sv */
// Header parser and payload unmasker: state plus one byte of work per beat
module wsd_parser #(
	parameter int LENGTH_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        in_byte,
	input  logic              new_stream,
	input  wsd_pkg::cfg_t     cfg,
	output logic              produce,
	output wsd_pkg::result_t  res,
	output logic              halted
);

	localparam int CW = (LENGTH_BITS >= 63) ? 63 : LENGTH_BITS;
	localparam logic [CW-1:0] LEN_CAP = {CW{1'b1}};

	wsd_pkg::phase_t phase_q, phase_nx, phase_cur;
	logic            halted_q, halted_nx, halted_cur;
	logic [3:0]      opcode_q, opcode_nx;
	logic [3:0]      hcount_q, hcount_nx;
	logic [CW-1:0]   acc_q, acc_nx;
	logic            ovf_q, ovf_nx;
	logic [31:0]     key_q, key_nx;
	logic [1:0]      mpos_q, mpos_nx;
	logic [CW-1:0]   remain_q, remain_nx;
	logic            masked_q, masked_nx;

	logic [CW-1:0]   acc_sh, remain_dec;
	logic            ovf_sh;
	logic [6:0]      len_code;
	logic [7:0]      key_byte;

	// length-done inputs and checks
	logic [CW-1:0]   ld_len;
	logic [3:0]      ld_hc;
	logic            ld_masked, ld_big, ld_err;
	logic [8:0]      ld_total;
	wsd_pkg::err_t   ld_code;

	logic            ld_c, fail_c, hdr_c, data_c, data_last_c;
	wsd_pkg::err_t   fail_code_c;
	logic [CW-1:0]   fail_len_c, hdr_len_c;

	assign phase_cur  = new_stream ? wsd_pkg::PH_FIRST : phase_q;
	assign halted_cur = new_stream ? 1'b0 : halted_q;

	assign len_code   = in_byte[6:0];
	assign acc_sh     = {acc_q[CW-9:0], in_byte};
	assign ovf_sh     = ovf_q | (|acc_q[CW-1:CW-8]);
	assign remain_dec = remain_q - CW'(1);
	assign key_byte   = key_q[{~mpos_q, 3'b000} +: 8];

	always_comb begin
		if (phase_cur == wsd_pkg::PH_EXT) begin
			ld_len    = ovf_sh ? LEN_CAP : acc_sh;
			ld_hc     = hcount_q + 4'd1;
			ld_masked = masked_q;
		end else begin
			ld_len    = CW'(len_code);
			ld_hc     = 4'd2;
			ld_masked = in_byte[7];
		end
	end

	assign ld_big   = |ld_len[CW-1:8];
	assign ld_total = 9'(ld_len[7:0]) + 9'(ld_hc) + (ld_masked ? 9'd4 : 9'd0);

	always_comb begin
		ld_err  = 1'b0;
		ld_code = wsd_pkg::ERR_NONE;
		if (opcode_q == wsd_pkg::OP_CONT) begin
			ld_err  = 1'b1;
			ld_code = wsd_pkg::ERR_CONT;
		end else if (opcode_q == wsd_pkg::OP_PING || opcode_q == wsd_pkg::OP_PONG) begin
			if (ld_len > CW'(cfg.max_control_payload)) begin
				ld_err  = 1'b1;
				ld_code = wsd_pkg::ERR_CTRL_LONG;
			end
		end else if (opcode_q == wsd_pkg::OP_CONN_END) begin
			if (ld_len >= CW'(2) && (ld_big || ld_total > 9'(cfg.max_close_frame))) begin
				ld_err  = 1'b1;
				ld_code = wsd_pkg::ERR_CLOSE_LONG;
			end
		end else if (opcode_q != wsd_pkg::OP_TEXT && opcode_q != wsd_pkg::OP_BINARY) begin
			ld_err  = 1'b1;
			ld_code = wsd_pkg::ERR_BAD_OPCODE;
		end
	end

	always_comb begin
		phase_nx    = phase_q;
		halted_nx   = halted_q;
		opcode_nx   = opcode_q;
		hcount_nx   = hcount_q;
		acc_nx      = acc_q;
		ovf_nx      = ovf_q;
		key_nx      = key_q;
		mpos_nx     = mpos_q;
		remain_nx   = remain_q;
		masked_nx   = masked_q;
		ld_c        = 1'b0;
		fail_c      = 1'b0;
		fail_code_c = wsd_pkg::ERR_NONE;
		fail_len_c  = '0;
		hdr_c       = 1'b0;
		hdr_len_c   = '0;
		data_c      = 1'b0;
		data_last_c = 1'b0;
		if (fire) begin
			phase_nx  = phase_cur;
			halted_nx = halted_cur;
			if (!halted_cur) begin
				case (phase_cur)
					wsd_pkg::PH_FIRST: begin
						opcode_nx = in_byte[3:0];
						hcount_nx = 4'd1;
						acc_nx    = '0;
						ovf_nx    = 1'b0;
						key_nx    = '0;
						mpos_nx   = '0;
						remain_nx = '0;
						if (!in_byte[7]) begin
							fail_c      = 1'b1;
							fail_code_c = wsd_pkg::ERR_FRAGMENTED;
						end else begin
							phase_nx = wsd_pkg::PH_SECOND;
						end
					end
					wsd_pkg::PH_SECOND: begin
						hcount_nx = 4'd2;
						if (!in_byte[7] && cfg.mask_required) begin
							fail_c      = 1'b1;
							fail_code_c = wsd_pkg::ERR_UNMASKED;
						end else if (len_code == wsd_pkg::LEN_CODE_16 ||
								len_code == wsd_pkg::LEN_CODE_64) begin
							remain_nx = (len_code == wsd_pkg::LEN_CODE_64) ? CW'(8) : CW'(2);
							acc_nx    = '0;
							ovf_nx    = 1'b0;
							masked_nx = in_byte[7];
							phase_nx  = wsd_pkg::PH_EXT;
						end else begin
							ld_c = 1'b1;
						end
					end
					wsd_pkg::PH_EXT: begin
						hcount_nx = hcount_q + 4'd1;
						acc_nx    = acc_sh;
						ovf_nx    = ovf_sh;
						remain_nx = remain_dec;
						if (remain_dec == '0) begin
							ld_c = 1'b1;
						end
					end
					wsd_pkg::PH_MASK: begin
						hcount_nx = hcount_q + 4'd1;
						key_nx    = {key_q[23:0], in_byte};
						mpos_nx   = mpos_q + 2'd1;
						if (mpos_q == 2'd3) begin
							hdr_c     = 1'b1;
							hdr_len_c = acc_q;
						end
					end
					wsd_pkg::PH_PAYLOAD: begin
						data_c    = 1'b1;
						mpos_nx   = mpos_q + 2'd1;
						remain_nx = remain_dec;
						if (remain_dec == '0) begin
							data_last_c = 1'b1;
							phase_nx    = wsd_pkg::PH_FIRST;
							mpos_nx     = '0;
						end
					end
					default: phase_nx = wsd_pkg::PH_FIRST;
				endcase

				// length known: saturated length is kept, opcode checks run
				if (ld_c) begin
					acc_nx    = ld_len;
					ovf_nx    = 1'b0;
					masked_nx = ld_masked;
					if (ld_err) begin
						fail_c      = 1'b1;
						fail_code_c = ld_code;
						fail_len_c  = ld_len;
					end else if (ld_masked) begin
						mpos_nx  = '0;
						phase_nx = wsd_pkg::PH_MASK;
					end else begin
						key_nx    = '0;
						hdr_c     = 1'b1;
						hdr_len_c = ld_len;
					end
				end

				if (hdr_c) begin
					remain_nx = hdr_len_c;
					mpos_nx   = '0;
					phase_nx  = (hdr_len_c == '0) ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;
				end

				if (fail_c) begin
					halted_nx = 1'b1;
				end
			end
		end
	end

	always_comb begin
		produce         = fail_c | hdr_c | data_c;
		res.opcode      = opcode_nx;
		res.kind        = fail_c ? wsd_pkg::KIND_ERROR :
			(data_c ? wsd_pkg::KIND_DATA : wsd_pkg::KIND_HEADER);
		res.payload_len = fail_c ? 63'(fail_len_c) : (hdr_c ? 63'(hdr_len_c) : 63'(acc_q));
		res.data_byte   = data_c ? (in_byte ^ key_byte) : 8'd0;
		res.last        = hdr_c ? (hdr_len_c == '0) : data_last_c;
		res.error_code  = fail_c ? fail_code_c : wsd_pkg::ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsd_pkg::PH_FIRST;
			halted_q <= 1'b0;
			opcode_q <= '0;
			hcount_q <= '0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			key_q    <= '0;
			mpos_q   <= '0;
			remain_q <= '0;
			masked_q <= 1'b0;
		end else begin
			phase_q  <= phase_nx;
			halted_q <= halted_nx;
			opcode_q <= opcode_nx;
			hcount_q <= hcount_nx;
			acc_q    <= acc_nx;
			ovf_q    <= ovf_nx;
			key_q    <= key_nx;
			mpos_q   <= mpos_nx;
			remain_q <= remain_nx;
			masked_q <= masked_nx;
		end
	end

	assign halted = halted_q;

endmodule

/* sim/tb.sv */
// Testbench for websocket_frame_deframer: directed frames and random byte streams against a frame parser model
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN_BITS = 64;
	localparam logic [63:0] LEN_CAP = (LEN_BITS >= 63) ? 64'h7FFF_FFFF_FFFF_FFFF :
		((64'd1 << LEN_BITS) - 64'd1);
	localparam int CYCLE_LIMIT = 400000;
	localparam int BEATS_PER_PHASE = 200;

	// Parser model plus the queue of records it predicts
	class deframe_tracker;
		logic [6:0]        max_ctrl;
		logic [7:0]        max_close;
		logic              mask_req;
		wsd_pkg::phase_t   phase;
		logic              ext_masked;
		logic [3:0]        hdr_cnt;
		logic [3:0]        op;
		logic [63:0]       acc;
		logic [63:0]       left;
		logic [31:0]       key;
		logic [1:0]        pos;
		logic              halted;
		wsd_pkg::result_t  pending_records[$];
		int                mismatches;

		function new();
			max_ctrl = wsd_pkg::MAX_CONTROL_RST;
			max_close = wsd_pkg::MAX_CLOSE_RST;
			mask_req = 1'b1;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			phase = wsd_pkg::PH_FIRST;
			ext_masked = 1'b0;
			hdr_cnt = '0;
			op = '0;
			acc = '0;
			left = '0;
			key = '0;
			pos = '0;
			halted = 1'b0;
		endfunction

		function void set_reg(logic [wsd_pkg::CFG_INDEX_W-1:0] idx,
			logic [wsd_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				wsd_pkg::REG_MAX_CONTROL: max_ctrl = val[6:0];
				wsd_pkg::REG_MAX_CLOSE:   max_close = val;
				wsd_pkg::REG_MASK_REQ:    mask_req = val[0];
				default: ;
			endcase
		endfunction

		function void add_record(wsd_pkg::kind_t k, logic [63:0] len, logic [7:0] d, logic l,
			wsd_pkg::err_t e);
			wsd_pkg::result_t r;
			r.kind = k;
			r.opcode = op;
			r.payload_len = len[62:0];
			r.data_byte = d;
			r.last = l;
			r.error_code = e;
			pending_records.push_back(r);
		endfunction

		function void raise_error(wsd_pkg::err_t e, logic [63:0] len);
			halted = 1'b1;
			add_record(wsd_pkg::KIND_ERROR, len, 8'h00, 1'b0, e);
		endfunction

		function void close_header();
			left = acc;
			pos = '0;
			if (acc == 0)
				phase = wsd_pkg::PH_FIRST;
			else
				phase = wsd_pkg::PH_PAYLOAD;
			add_record(wsd_pkg::KIND_HEADER, acc, 8'h00, acc == 0, wsd_pkg::ERR_NONE);
		endfunction

		function void close_length(logic [63:0] raw, logic masked);
			logic [63:0] len;
			logic [63:0] total;
			wsd_pkg::err_t e;
			len = (raw > LEN_CAP) ? LEN_CAP : raw;
			acc = len;
			e = wsd_pkg::ERR_NONE;
			total = len + hdr_cnt + (masked ? 64'd4 : 64'd0);
			if (op == wsd_pkg::OP_CONT)
				e = wsd_pkg::ERR_CONT;
			else if (op == wsd_pkg::OP_PING || op == wsd_pkg::OP_PONG) begin
				if (len > max_ctrl)
					e = wsd_pkg::ERR_CTRL_LONG;
			end else if (op == wsd_pkg::OP_CONN_END) begin
				if (len >= 2 && (len > 255 || total > max_close))
					e = wsd_pkg::ERR_CLOSE_LONG;
			end else if (op != wsd_pkg::OP_TEXT && op != wsd_pkg::OP_BINARY)
				e = wsd_pkg::ERR_BAD_OPCODE;
			if (e != wsd_pkg::ERR_NONE)
				raise_error(e, len);
			else if (masked) begin
				pos = '0;
				phase = wsd_pkg::PH_MASK;
			end else begin
				key = '0;
				close_header();
			end
		endfunction

		function void take_byte(logic [7:0] b, logic ns);
			logic       masked;
			logic [6:0] code;
			logic [7:0] d;
			logic       l;
			int         sh;
			if (ns)
				restart();
			if (halted)
				return;
			case (phase)
				wsd_pkg::PH_FIRST: begin
					op = b[3:0];
					hdr_cnt = 4'd1;
					acc = '0;
					key = '0;
					pos = '0;
					left = '0;
					if (!b[7])
						raise_error(wsd_pkg::ERR_FRAGMENTED, 64'd0);
					else
						phase = wsd_pkg::PH_SECOND;
				end
				wsd_pkg::PH_SECOND: begin
					masked = b[7];
					code = b[6:0];
					hdr_cnt = 4'd2;
					if (!masked && mask_req)
						raise_error(wsd_pkg::ERR_UNMASKED, 64'd0);
					else if (code == wsd_pkg::LEN_CODE_16 || code == wsd_pkg::LEN_CODE_64) begin
						left = (code == wsd_pkg::LEN_CODE_16) ? 64'd2 : 64'd8;
						acc = '0;
						ext_masked = masked;
						phase = wsd_pkg::PH_EXT;
					end else
						close_length({57'd0, code}, masked);
				end
				wsd_pkg::PH_EXT: begin
					hdr_cnt = hdr_cnt + 4'd1;
					acc = {acc[55:0], b};
					left = left - 64'd1;
					if (left == 0)
						close_length(acc, ext_masked);
				end
				wsd_pkg::PH_MASK: begin
					hdr_cnt = hdr_cnt + 4'd1;
					key = {key[23:0], b};
					pos = pos + 2'd1;
					if (pos == 0)
						close_header();
				end
				wsd_pkg::PH_PAYLOAD: begin
					sh = 24 - 8 * pos;
					d = b ^ 8'(key >> sh);
					pos = pos + 2'd1;
					left = left - 64'd1;
					l = (left == 0);
					if (l) begin
						phase = wsd_pkg::PH_FIRST;
						pos = '0;
					end
					add_record(wsd_pkg::KIND_DATA, acc, d, l, wsd_pkg::ERR_NONE);
				end
				default: phase = wsd_pkg::PH_FIRST;
			endcase
		endfunction

		function void match_record(wsd_pkg::result_t got);
			wsd_pkg::result_t want;
			if (pending_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record: kind %0d op %0h len %0d data %02h last %0b err %0d",
						got.kind, got.opcode, got.payload_len, got.data_byte, got.last,
						got.error_code);
				return;
			end
			want = pending_records.pop_front();
			if (got.kind !== want.kind || got.opcode !== want.opcode ||
				got.payload_len !== want.payload_len || got.data_byte !== want.data_byte ||
				got.last !== want.last || got.error_code !== want.error_code) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("expected: kind %0d op %0h len %0d data %02h last %0b err %0d",
						want.kind, want.opcode, want.payload_len, want.data_byte, want.last,
						want.error_code);
					$display("actual:   kind %0d op %0h len %0d data %02h last %0b err %0d",
						got.kind, got.opcode, got.payload_len, got.data_byte, got.last,
						got.error_code);
				end
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [wsd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_data;

	wsd_in_if  stream_if();
	wsd_out_if rec_if();

	deframe_tracker board;
	bit idle_on;
	bit idle_allowed;
	bit risky;
	int beats_sent;
	int cycles;

	websocket_frame_deframer #(.LENGTH_BITS(LEN_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.stream(stream_if),
		.records(rec_if)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Sample both channels at the rising edge
	always @(posedge clk) begin : watch
		wsd_pkg::result_t got;
		if (arst_n === 1'b1) begin
			if (rec_if.valid && rec_if.ready) begin
				got.kind = wsd_pkg::kind_t'(rec_if.kind);
				got.opcode = rec_if.opcode;
				got.payload_len = rec_if.payload_len;
				got.data_byte = rec_if.data_byte;
				got.last = rec_if.last;
				got.error_code = wsd_pkg::err_t'(rec_if.error_code);
				board.match_record(got);
			end
			if (stream_if.valid && stream_if.ready)
				board.take_byte(stream_if.in_byte, stream_if.new_stream);
		end
	end

	// Record sink with random stall bursts
	always begin
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			rec_if.ready <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		rec_if.ready <= 1'b1;
	end

	task automatic push_byte(input logic [7:0] b, input logic ns);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			stream_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.in_byte <= b;
		stream_if.new_stream <= ns;
		@(posedge clk);
		while (!stream_if.ready) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [wsd_pkg::CFG_INDEX_W-1:0] idx,
		input logic [wsd_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		board.set_reg(idx, val);
		@(negedge clk);
	endtask

	// Let every record drain, then let bytes that produce none clear the deframer too
	task automatic wait_drained();
		stream_if.valid <= 1'b0;
		while (board.pending_records.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic apply_config(input logic [6:0] ctrl, input logic [7:0] close_max,
		input logic mreq);
		wait_drained();
		write_reg(wsd_pkg::REG_MAX_CONTROL, {1'b0, ctrl});
		write_reg(wsd_pkg::REG_MAX_CLOSE, close_max);
		write_reg(wsd_pkg::REG_MASK_REQ, {7'd0, mreq});
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_form(logic [63:0] len);
		if (len >= 65536)
			return 2;
		if (len >= 126)
			return 1;
		case ($urandom_range(0, 11))
			0: return 1;
			1: return 2;
			default: return 0;
		endcase
	endfunction

	function automatic int header_size(int form);
		return (form == 0) ? 2 : (form == 1) ? 4 : 10;
	endfunction

	// Build one frame and send its first cut bytes
	task automatic send_frame(input logic [3:0] fop, input logic fin, input logic masked,
		input int form, input logic [63:0] len, input int npay, input int cut, input logic ns);
		logic [7:0] bytes[$];
		logic [2:0] rsv;
		int i;
		rsv = $urandom_range(0, 7);
		bytes.push_back({fin, rsv, fop});
		if (form == 0)
			bytes.push_back({masked, len[6:0]});
		else if (form == 1) begin
			bytes.push_back({masked, wsd_pkg::LEN_CODE_16});
			bytes.push_back(len[15:8]);
			bytes.push_back(len[7:0]);
		end else begin
			bytes.push_back({masked, wsd_pkg::LEN_CODE_64});
			for (i = 7; i >= 0; i--)
				bytes.push_back(len[i*8 +: 8]);
		end
		if (masked)
			repeat (4) bytes.push_back($urandom_range(0, 255));
		repeat (npay) bytes.push_back($urandom_range(0, 255));
		for (i = 0; i < bytes.size() && i < cut; i++)
			push_byte(bytes[i], (i == 0) ? ns : 1'b0);
	endtask

	task automatic random_frame();
		int pick;
		int form;
		int n;
		int thr;
		logic [63:0] len;
		logic [3:0] fop;
		logic masked;
		logic fin;
		logic ns;
		logic bad;
		ns = risky || ($urandom_range(0, 7) == 0);
		idle_on = idle_allowed && ($urandom_range(0, 5) != 0);
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			fop = $urandom_range(0, 1) ? wsd_pkg::OP_TEXT : wsd_pkg::OP_BINARY;
			masked = board.mask_req ? ($urandom_range(0, 15) != 0) : $urandom_range(0, 1);
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(126, 300);
			else
				len = $urandom_range(0, 12);
			form = pick_form(len);
			bad = !masked && board.mask_req;
			send_frame(fop, 1'b1, masked, form, len, bad ? 0 : int'(len), 1000, ns);
			risky = bad;
		end else if (pick < 70) begin
			case ($urandom_range(0, 2))
				0: fop = wsd_pkg::OP_PING;
				1: fop = wsd_pkg::OP_PONG;
				default: fop = wsd_pkg::OP_CONN_END;
			endcase
			if (fop == wsd_pkg::OP_CONN_END) begin
				thr = int'(board.max_close) - 6;
				if ($urandom_range(0, 2) == 0) begin
					n = thr - 1 + $urandom_range(0, 2);
					if (n < 0)
						n = $urandom_range(0, 3);
				end else
					n = $urandom_range(0, 6);
				len = n;
				form = pick_form(len);
				bad = len >= 2 && (len > 255 || len + header_size(form) + 4 > board.max_close);
			end else begin
				if ($urandom_range(0, 2) == 0)
					len = board.max_ctrl + $urandom_range(0, 1);
				else
					len = $urandom_range(0, 8);
				form = pick_form(len);
				bad = len > board.max_ctrl;
			end
			send_frame(fop, 1'b1, 1'b1, form, len, bad ? 0 : int'(len), 1000, ns);
			risky = bad;
		end else if (pick < 80) begin
			// continuation, reserved opcodes, FIN clear
			fin = ($urandom_range(0, 3) != 0);
			n = $urandom_range(0, 10);
			if (n == 0)
				fop = wsd_pkg::OP_CONT;
			else if (n < 6)
				fop = 4'(n + 2);
			else
				fop = 4'(n + 5);
			len = $urandom_range(0, 3);
			send_frame(fop, fin, 1'b1, 0, len, int'(len), 1000, ns);
			risky = 1'b1;
		end else if (pick < 90) begin
			// cut short, often with a huge or saturating 64-bit length
			fop = $urandom_range(0, 1) ? wsd_pkg::OP_TEXT : wsd_pkg::OP_BINARY;
			if ($urandom_range(0, 2) == 0) begin
				len = {$urandom, $urandom};
				form = 2;
			end else begin
				len = $urandom_range(0, 40);
				form = pick_form(len);
			end
			send_frame(fop, 1'b1, 1'b1, form, len, 3, $urandom_range(1, header_size(form) + 7),
				ns);
			risky = 1'b1;
		end else begin
			repeat ($urandom_range(1, 6))
				push_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
			risky = 1'b1;
		end
	endtask

	initial begin
		int p;
		int start;
		logic [6:0] ctrl;
		logic [7:0] close_max;
		logic mreq;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = wsd_pkg::REG_MAX_CONTROL;
		cfg_data = '0;
		stream_if.valid = 1'b0;
		stream_if.in_byte = '0;
		stream_if.new_stream = 1'b0;
		rec_if.ready = 1'b0;
		idle_on = 1'b1;
		idle_allowed = 1'b1;
		risky = 1'b0;
		beats_sent = 0;
		cycles = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames under reset settings
		send_frame(wsd_pkg::OP_TEXT, 1'b1, 1'b1, 0, 64'd0, 0, 1000, 1'b0);
		send_frame(wsd_pkg::OP_PING, 1'b1, 1'b1, 0, 64'd1, 1, 1000, 1'b0);
		send_frame(wsd_pkg::OP_TEXT, 1'b0, 1'b1, 0, 64'd0, 0, 1, 1'b0);
		send_frame(wsd_pkg::OP_BINARY, 1'b1, 1'b0, 0, 64'd0, 0, 1000, 1'b1);
		send_frame(wsd_pkg::OP_CONT, 1'b1, 1'b1, 0, 64'd0, 0, 2, 1'b1);
		send_frame(4'hF, 1'b1, 1'b1, 0, 64'd0, 0, 2, 1'b1);
		send_frame(wsd_pkg::OP_PONG, 1'b1, 1'b1, 1, 64'd126, 0, 4, 1'b1);
		send_frame(wsd_pkg::OP_CONN_END, 1'b1, 1'b1, 1, 64'd200, 0, 4, 1'b1);
		risky = 1'b1;

		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin ctrl = 7'd0; close_max = 8'd0; mreq = 1'b0; end
				1: begin ctrl = 7'd125; close_max = 8'd255; mreq = 1'b1; end
				3: begin ctrl = 7'd1; close_max = 8'd10; mreq = 1'b1; end
				5: begin
					ctrl = wsd_pkg::MAX_CONTROL_RST;
					close_max = wsd_pkg::MAX_CLOSE_RST;
					mreq = 1'b1;
				end
				default: begin
					ctrl = $urandom_range(0, 125);
					close_max = $urandom_range(0, 255);
					mreq = $urandom_range(0, 1);
				end
			endcase
			apply_config(ctrl, close_max, mreq);
			idle_allowed = (p != 5);
			start = beats_sent;
			while (beats_sent - start < BEATS_PER_PHASE)
				random_frame();
		end

		stream_if.valid <= 1'b0;
		while (board.pending_records.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (board.mismatches == 0 && board.pending_records.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
